>>> rtl/iopc_pkg.sv
// ----------------------------------------------------------------------------
// iopc_pkg
// Shared types and constants for the checked integer power block.
// ----------------------------------------------------------------------------
`default_nettype none

package iopc_pkg;

   // Field width of the transfer payloads, fixed by the interface.
   localparam int FIELD_W = 64;

   typedef struct packed {
      logic signed [FIELD_W-1:0] base;
      logic signed [FIELD_W-1:0] exponent;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] power;
      logic                      overflow;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic start_r;
      logic start_sq;
      logic latch_r;
      logic latch_sq;
      logic shift_e;
      logic set_ovf;
      logic fin;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic trivial;
      logic e_bit0;
      logic e_rest_zero;
      logic sq_big;
      logic mul_done;
      logic mul_big;
   } stat_type;

endpackage : iopc_pkg

`default_nettype wire

>>> rtl/iopc_mul.sv
// ----------------------------------------------------------------------------
// iopc_mul
// Unsigned multiplier, one quarter of the second operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iopc_mul #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         done,
   output logic         big,
   output logic [W-1:0] lo
);
   localparam int NQ    = 4;
   localparam int Q     = (W + NQ - 1) / NQ;
   localparam int BP    = NQ * Q;
   localparam int PW    = W + BP;
   localparam int PPW   = W + Q;
   localparam int CNT_W = $clog2(NQ);

   logic [W-1:0]     a_ff;
   logic [BP-1:0]    b_sh_ff, b_sh_in;
   logic [PW-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [PPW-1:0]   pp;
   logic [W-1:0]     half;

   // partial product of a against the current top chunk
   assign pp   = PPW'(a_ff) * PPW'(b_sh_ff[BP-1 -: Q]);
   assign half = W'(1) << (W - 1);

   always_comb begin
      b_sh_in = b_sh_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         b_sh_in = BP'(b);
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = {acc_ff[PW-Q-1:0], {Q{1'b0}}} + PW'(pp);
         b_sh_in = b_sh_ff << Q;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NQ - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
      end
      b_sh_ff <= b_sh_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign lo   = acc_ff[W-1:0];
   assign big  = (acc_ff[PW-1:W] != '0) || (acc_ff[W-1:0] > half);

endmodule : iopc_mul

`default_nettype wire

>>> rtl/iopc_dpath.sv
// ----------------------------------------------------------------------------
// iopc_dpath
// Operand registers, square-and-multiply datapath and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iopc_dpath #(
   parameter int W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  iopc_pkg::req_type req_data,
   input  iopc_pkg::cmd_type cmd,
   output iopc_pkg::stat_type stat,
   output iopc_pkg::rsp_type rsp_data
);
   import iopc_pkg::*;

   logic [W-1:0]       base_w, exp_w, mag, half, mul_a, mul_lo, res_mag, res_w;
   logic               bneg, eneg, ezero, mag_le1;
   logic [W-1:0]       r_ff, sq_ff;
   logic [W-2:0]       e_rem_ff;
   logic               sq_big_ff, ovf_ff, odd_ff, bneg_ff, trivial_ff;
   logic [FIELD_W-1:0] power_ff;
   logic               ovf_out_ff;
   logic               mul_done, mul_big, rneg, ovf_fin;

   assign half    = W'(1) << (W - 1);
   assign base_w  = req_data.base[W-1:0];
   assign exp_w   = req_data.exponent[W-1:0];
   assign bneg    = base_w[W-1];
   assign eneg    = exp_w[W-1];
   assign ezero   = (exp_w == '0);
   assign mag     = bneg ? (W'(0) - base_w) : base_w;
   assign mag_le1 = (mag[W-1:1] == '0);

   assign mul_a = cmd.start_sq ? sq_ff : r_ff;

   iopc_mul #(.W(W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_r | cmd.start_sq),
      .a     (mul_a),
      .b     (sq_ff),
      .done  (mul_done),
      .big   (mul_big),
      .lo    (mul_lo)
   );

   // sign and range check on the final magnitude
   assign rneg    = bneg_ff && odd_ff && (r_ff != '0);
   assign ovf_fin = ovf_ff || (rneg ? (r_ff > half) : (r_ff >= half));
   assign res_mag = rneg ? (W'(0) - r_ff) : r_ff;
   assign res_w   = ovf_fin ? '0 : res_mag;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         // zero for a negative exponent or a zero base with a nonzero exponent, else the empty product
         r_ff       <= (eneg || (!ezero && (mag == '0))) ? W'(0) : W'(1);
         sq_ff      <= mag;
         sq_big_ff  <= 1'b0;
         ovf_ff     <= 1'b0;
         e_rem_ff   <= exp_w[W-2:0];
         odd_ff     <= exp_w[0];
         bneg_ff    <= bneg;
         trivial_ff <= eneg || ezero || mag_le1;
      end else begin
         if (cmd.latch_r) begin
            r_ff <= mul_lo;
            if (mul_big) begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.latch_sq) begin
            sq_ff <= mul_lo;
            if (mul_big) begin
               sq_big_ff <= 1'b1;
            end
         end
         if (cmd.shift_e) begin
            e_rem_ff <= e_rem_ff >> 1;
         end
         if (cmd.set_ovf) begin
            ovf_ff <= 1'b1;
         end
      end
      if (cmd.fin) begin
         power_ff   <= FIELD_W'(res_w);
         ovf_out_ff <= ovf_fin;
      end
   end

   assign stat.trivial     = trivial_ff;
   assign stat.e_bit0      = e_rem_ff[0];
   assign stat.e_rest_zero = (e_rem_ff[W-2:1] == '0);
   assign stat.sq_big      = sq_big_ff;
   assign stat.mul_done    = mul_done;
   assign stat.mul_big     = mul_big;

   assign rsp_data.power    = power_ff;
   assign rsp_data.overflow = ovf_out_ff;

endmodule : iopc_dpath

`default_nettype wire

>>> rtl/iopc_ctrl.sv
// ----------------------------------------------------------------------------
// iopc_ctrl
// Sequencer for the square-and-multiply loop and the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module iopc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  iopc_pkg::stat_type  stat,
   output iopc_pkg::cmd_type   cmd
);
   import iopc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_MUL_R  = 6'b000100,
      ST_NEXT   = 6'b001000,
      ST_MUL_SQ = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.trivial) begin
               state_in = ST_DONE;
            end else if (stat.e_bit0 && stat.sq_big) begin
               // this square is already past the range and is a factor
               cmd.set_ovf = 1'b1;
               state_in    = ST_DONE;
            end else if (stat.e_bit0) begin
               cmd.start_r = 1'b1;
               state_in    = ST_MUL_R;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_MUL_R: begin
            if (stat.mul_done) begin
               cmd.latch_r = 1'b1;
               state_in    = stat.mul_big ? ST_DONE : ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.shift_e = 1'b1;
            if (stat.e_rest_zero) begin
               state_in = ST_DONE;
            end else if (stat.sq_big) begin
               cmd.set_ovf = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.start_sq = 1'b1;
               state_in     = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (stat.mul_done) begin
               cmd.latch_sq = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : iopc_ctrl

`default_nettype wire

>>> rtl/int64_power_overflow_checked.sv
// ----------------------------------------------------------------------------
// int64_power_overflow_checked
// Signed integer power with overflow detection, square-and-multiply.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload    transfer when
//   req_      in    req_type   req_valid  && !req_stall
//   rsp_      out   rsp_type   rsp_valid  && !rsp_stall
//
// Loop: skipped for a negative or zero exponent, or a base of 0, +1 or -1.
//   Otherwise one pass per exponent bit examined; the shared multiplier
//   forms one quarter-width partial product per cycle, and the loop stops
//   once the running square or the running product leaves the range.
// Reset: synchronous, clears the sequencer and the result valid flag.
// Stalls: a finished result sits in the output register; the next request
//   is taken while it waits, and only the final write blocks on rsp_stall.
//
`default_nettype none

module int64_power_overflow_checked #(
   parameter int DATA_WIDTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iopc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iopc_pkg::rsp_type rsp_data
);
   import iopc_pkg::*;

   cmd_type  cmd;   // sequencer commands
   stat_type stat;  // loop status back to the sequencer

   // Control: one-hot sequencer, owns both handshakes.
   iopc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Data: magnitude, running square, running product and result register.
   // Bits of the fields above DATA_WIDTH are ignored on input, zero on output.
   iopc_dpath #(.W(DATA_WIDTH)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule : int64_power_overflow_checked

`default_nettype wire

>>> rtl/iopc_check.sv
// ----------------------------------------------------------------------------
// iopc_check
// Port-level checks for the checked integer power block.
// ----------------------------------------------------------------------------
`default_nettype none

module iopc_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input iopc_pkg::rsp_type rsp_data
);
   import iopc_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transfer changed while stalled");

   // overflow always reports a zero power
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.power == '0)
      else $error("overflow with nonzero power");

   // one job at a time: a taken request closes the input
   a_one_job: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule : iopc_check

bind int64_power_overflow_checked iopc_check u_iopc_check (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checked signed 64-bit power block: directed
// corner cases, then randomized base/exponent transfers under random
// sender bursts and receiver stall patterns, scored against a local model.
// ----------------------------------------------------------------------------

module tb_top;
   import iopc_pkg::*;

   // Arithmetic limits of the 64-bit signed range.
   localparam bit [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam bit [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam int RANDOM_ITEMS   = 1750;
   localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
   localparam int DRAIN_CYCLES   = 200;   // settle time after the last result
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
   localparam int REPORT_LIMIT   = 10;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_type;

   typedef struct {
      req_type cause;
      rsp_type result;
   } power_entry_type;

   // -------------------------------------------------------------------------
   // Scoreboard: computes the expected power for each accepted request and
   // matches results in order.
   // -------------------------------------------------------------------------
   class power_scoreboard;
      power_entry_type expected_powers[$];
      int unsigned     mismatch_count = 0;

      function rsp_type predict_power(req_type r);
         bit [63:0] b;
         bit [63:0] e;
         bit [63:0] mag;
         bit [63:0] acc;
         bit [63:0] cnt;
         bit        neg_res;
         bit        ovf;
         rsp_type   res;
         b       = r.base;
         e       = r.exponent;
         ovf     = 1'b0;
         acc     = '0;
         res     = '0;
         if (e[63]) begin
            res.power = '0;                 // negative exponent
         end else if (e == 0) begin
            res.power = 64'd1;              // x^0 = 1, zero base too
         end else begin
            mag = b[63] ? -b : b;
            acc = mag;
            if (mag >= 2) begin
               // acc at least doubles per factor: overflow within 64 rounds
               for (cnt = 1; cnt < e; cnt++) begin
                  if (acc > SIGN_BIT / mag) begin
                     ovf = 1'b1;
                     break;
                  end
                  acc = acc * mag;
                  if (acc > SIGN_BIT) begin
                     ovf = 1'b1;
                     break;
                  end
               end
            end else if (mag == 0) begin
               acc = '0;
            end else begin
               acc = 64'd1;
            end
            neg_res = b[63] && e[0] && (acc != 0);
            // 2^63 only fits as a negative result
            if (!ovf && (neg_res ? (acc > SIGN_BIT) : (acc > MAX_POS)))
               ovf = 1'b1;
            if (ovf)
               res.power = '0;
            else
               res.power = neg_res ? -acc : acc;
         end
         res.overflow = ovf;
         return res;
      endfunction

      function void note_request(req_type r);
         power_entry_type ent;
         ent.cause  = r;
         ent.result = predict_power(r);
         expected_powers.push_back(ent);
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction

      function void score_result(rsp_type got);
         power_entry_type want;
         if (expected_powers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: power=%0d overflow=%0b",
                        got.power, got.overflow);
            return;
         end
         want = expected_powers.pop_front();
         if (got.power !== want.result.power ||
             got.overflow !== want.result.overflow) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("mismatch: base=%0d exp=%0d power exp %0d got %0d, ovf exp %0b got %0b",
                        want.cause.base, want.cause.exponent,
                        want.result.power, got.power,
                        want.result.overflow, got.overflow);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT signals. Every bench-driven signal starts at a known value.
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   power_scoreboard power_sb = new;

   bit          hold_off_req = 1'b0;  // main flow asks the receiver for a long hold
   int unsigned burst_left   = 0;     // transfers left in the current sender burst
   int unsigned quiet_cycles = 0;     // watchdog count

   always #5 clock = ~clock;

   int64_power_overflow_checked u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic req_type make_req(bit [63:0] b, bit [63:0] e);
      req_type r;
      r.base     = b;
      r.exponent = e;
      return r;
   endfunction

   // Mostly bases of random bit width with exponents near the overflow
   // boundary for that width; some full-range noise, negative exponents
   // and bases from -2 to 2 with huge exponents.
   function automatic req_type random_req();
      req_type     r;
      bit [63:0]   mag;
      int unsigned width;
      int unsigned pick;
      pick  = $urandom_range(0, 15);
      width = $urandom_range(1, 64);
      mag   = {$urandom, $urandom} >> (64 - width);
      if (pick == 0) begin
         r.base     = {$urandom, $urandom};
         r.exponent = {$urandom, $urandom};
      end else if (pick == 1) begin
         r.base     = {$urandom, $urandom};
         r.exponent = 64'($urandom_range(0, 3));
      end else if (pick == 2) begin
         r.base     = 64'($urandom_range(0, 4)) - 64'd2;
         r.exponent = {$urandom, $urandom};
      end else begin
         r.base = $urandom_range(0, 1) ? -mag : mag;
         if (pick == 3)
            r.exponent = {1'b1, 31'($urandom), $urandom};
         else
            r.exponent = 64'($urandom_range(0, 63 / width + 2));
      end
      return r;
   endfunction

   // Offer one request; drive at negedge, accept at a posedge with no stall.
   // Bursts of random length, mostly separated by random gaps (occasionally long).
   task automatic push_item(input req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 60);
         if ($urandom_range(0, 3) != 0) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      power_sb.note_request(item);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: stall pattern changes mode every so often; a long hold-off
   // runs when the main flow requests one, counted here.
   // -------------------------------------------------------------------------
   initial begin
      stall_mode_type mode;
      int unsigned    mode_left;
      int unsigned    period;
      int unsigned    phase;
      mode      = STALL_NONE;
      mode_left = 0;
      period    = 2;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 300);
               period    = $urandom_range(2, 9);
               phase     = 0;
            end
            mode_left--;
            phase++;
            case (mode)
               STALL_NONE:   rsp_stall <= 1'b0;
               STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
               default:      rsp_stall <= ((phase % period) == 0);
            endcase
         end
      end
   end

   // Score each result transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         power_sb.score_result(rsp_data);
   end

   // Watchdog: no transfer on either channel for too long ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main flow
   // -------------------------------------------------------------------------
   initial begin
      req_type     directed[$];
      int unsigned i;

      // negative exponents: result 0, no overflow
      directed.push_back(make_req(64'd5, -64'd1));
      directed.push_back(make_req(MAX_POS, SIGN_BIT));
      // zero exponent gives 1 for every base, zero included
      directed.push_back(make_req(64'd0, 64'd0));
      directed.push_back(make_req(SIGN_BIT, 64'd0));
      directed.push_back(make_req(MAX_POS, 64'd0));
      // bases zero, one, minus one with large exponents
      directed.push_back(make_req(64'd0, 64'd5));
      directed.push_back(make_req(64'd0, MAX_POS));
      directed.push_back(make_req(64'd1, MAX_POS));
      directed.push_back(make_req(-64'd1, MAX_POS));
      directed.push_back(make_req(-64'd1, MAX_POS - 64'd1));
      // most negative and most positive base
      directed.push_back(make_req(SIGN_BIT, 64'd1));
      directed.push_back(make_req(SIGN_BIT, 64'd2));
      directed.push_back(make_req(MAX_POS, 64'd1));
      directed.push_back(make_req(MAX_POS, 64'd2));
      // right at the overflow boundary
      directed.push_back(make_req(64'd2, 64'd62));
      directed.push_back(make_req(64'd2, 64'd63));
      directed.push_back(make_req(-64'd2, 64'd63));
      directed.push_back(make_req(-64'd2, 64'd64));
      directed.push_back(make_req(64'd3, 64'd39));
      directed.push_back(make_req(64'd3, 64'd40));
      directed.push_back(make_req(-64'd3, 64'd39));
      directed.push_back(make_req(64'd2, MAX_POS));
      directed.push_back(make_req(64'd7, 64'd1));
      directed.push_back(make_req(-64'd7, 64'd2));
      directed.push_back(make_req(64'd3037000499, 64'd2));
      directed.push_back(make_req(64'd3037000500, 64'd2));

      // hold the synchronous reset, then release it
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k])
         push_item(directed[k]);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         // receiver holds off while we keep offering: the block backs up
         if (i == 400 || i == 1400)
            hold_off_req = 1'b1;
         // sender goes quiet until the scoreboard is empty
         if (i == 900) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (power_sb.pending() != 0) @(posedge clock);
         end
         push_item(random_req());
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then give the block time to show any stray result
      while (power_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (power_sb.mismatch_count == 0 && power_sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
